[sv/scancode_decoder_key_queue_defines.svh]
// ----------------------------------------------------------------------------
// Scancode decoder key queue - assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_DECODER_KEY_QUEUE_DEFINES_SVH
`define SCANCODE_DECODER_KEY_QUEUE_DEFINES_SVH

// holds on every edge out of reset
`define SCKQ_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent checked on the edge after the antecedent
`define SCKQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// holds on the edge after reset has been seen
`define SCKQ_ASSERT_IN_RESET(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) !rst_n |=> (expr)) else $error(msg);

`endif

[sv/sckq_pkg.sv]
// ----------------------------------------------------------------------------
// Scancode decoder key queue - package
// Request codes, scancodes, logical key codes and inter-module structs.
// ----------------------------------------------------------------------------
package sckq_pkg;

    localparam int KEY_COUNT = 128;
    localparam int KEY_IW    = $clog2(KEY_COUNT);
    localparam int KEY_CNT_W = $clog2(KEY_COUNT + 1);

    localparam logic [1:0] OP_SCAN  = 2'd0;
    localparam logic [1:0] OP_POLL  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [7:0] BYTE_PREFIX = 8'hE0;

    localparam logic [6:0] SCAN_ESC   = 7'h01;
    localparam logic [6:0] SCAN_RETURN = 7'h1C;
    localparam logic [6:0] SCAN_BLANK = 7'h39;
    localparam logic [6:0] SCAN_UP    = 7'h48;
    localparam logic [6:0] SCAN_LEFT  = 7'h4B;
    localparam logic [6:0] SCAN_EAST  = 7'h4D;
    localparam logic [6:0] SCAN_DOWN  = 7'h50;

    localparam logic [2:0] KEY_NONE  = 3'd0;
    localparam logic [2:0] KEY_UP    = 3'd1;
    localparam logic [2:0] KEY_DOWN  = 3'd2;
    localparam logic [2:0] KEY_LEFT  = 3'd3;
    localparam logic [2:0] KEY_RIGHT = 3'd4;
    localparam logic [2:0] KEY_ENTER = 3'd5;
    localparam logic [2:0] KEY_ESC   = 3'd6;
    localparam logic [2:0] KEY_SPACE = 3'd7;

    typedef struct packed {
        logic              wr_en;
        logic              set;
        logic [KEY_IW-1:0] index;
    } key_req_t;

    typedef struct packed {
        logic is_down;
        logic any_down_next;
    } key_rsp_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [2:0] push_key;
    } fifo_req_t;

    typedef struct packed {
        logic [2:0] head_key;
        logic       nonempty;
        logic       nonempty_next;
    } fifo_rsp_t;

    function automatic logic [2:0] translate_make(input logic [6:0] code, input logic pref);
        logic [2:0] k;
        k = KEY_NONE;
        unique case (code)
            SCAN_ESC:    k = KEY_ESC;
            SCAN_RETURN: k = KEY_ENTER;
            SCAN_BLANK:  k = KEY_SPACE;
            SCAN_UP:     k = pref ? KEY_UP : KEY_NONE;
            SCAN_DOWN:   k = pref ? KEY_DOWN : KEY_NONE;
            SCAN_LEFT:   k = pref ? KEY_LEFT : KEY_NONE;
            SCAN_EAST:   k = pref ? KEY_RIGHT : KEY_NONE;
            default:     k = KEY_NONE;
        endcase
        return k;
    endfunction

endpackage

[sv/sckq_key_table.sv]
// ----------------------------------------------------------------------------
// Scancode decoder key queue - key-down table
// One bit per key, cleared by reset, plus a running count of keys held.
// ----------------------------------------------------------------------------
module sckq_key_table (
    input  logic               clk,
    input  logic               rst_n,
    input  sckq_pkg::key_req_t req,
    output sckq_pkg::key_rsp_t rsp
);
    import sckq_pkg::*;

    logic [KEY_COUNT-1:0] bits_reg;
    logic [KEY_CNT_W-1:0] count_reg;
    logic [KEY_CNT_W-1:0] count_next;
    logic                 old_bit;
    logic                 inc;
    logic                 dec;

    assign old_bit    = bits_reg[req.index];
    assign inc        = req.wr_en && req.set && !old_bit;
    assign dec        = req.wr_en && !req.set && old_bit;
    assign count_next = count_reg + KEY_CNT_W'(inc) - KEY_CNT_W'(dec);

    assign rsp.is_down       = old_bit;
    assign rsp.any_down_next = (count_next != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (req.wr_en)
            begin
                bits_reg[req.index] <= req.set;
            end
        end
    end

endmodule

[sv/sckq_event_fifo.sv]
// ----------------------------------------------------------------------------
// Scancode decoder key queue - event FIFO
// Ring buffer of logical key codes; head entry prefetched with write bypass.
// ----------------------------------------------------------------------------
module sckq_event_fifo #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sckq_pkg::fifo_req_t req,
    output sckq_pkg::fifo_rsp_t rsp
);
    import sckq_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [2:0]    mem [QUEUE_DEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic [PW-1:0] wp_next;
    logic [PW-1:0] rp_next;
    logic [PW-1:0] wp_inc;
    logic [PW-1:0] rp_inc;
    logic          do_push;
    logic          do_pop;
    logic [2:0]    rd_data_reg;
    logic [2:0]    byp_data_reg;
    logic          byp_reg;

    assign wp_inc  = (wp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc  = (rp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign do_push = req.push && (wp_inc != rp_reg);
    assign do_pop  = req.pop && (wp_reg != rp_reg);
    assign wp_next = do_push ? wp_inc : wp_reg;
    assign rp_next = do_pop ? rp_inc : rp_reg;

    assign rsp.head_key      = byp_reg ? byp_data_reg : rd_data_reg;
    assign rsp.nonempty      = (wp_reg != rp_reg);
    assign rsp.nonempty_next = (wp_next != rp_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            byp_reg <= 1'b0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            byp_reg <= do_push && (wp_reg == rp_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wp_reg] <= req.push_key;
        end
        rd_data_reg  <= mem[rp_next];
        byp_data_reg <= req.push_key;
    end

endmodule

[sv/scancode_decoder_key_queue.sv]
// ----------------------------------------------------------------------------
// Scancode decoder key queue - top level
// Set-1 scancode decoder with key-down table and logical key event queue.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the output is not held by out_stall;
// input register, one decode/update pass, result register.
// Reset: asynchronous; clears key table, key count, queue pointers, prefix
// flag and all valid flags. Queue storage is not cleared.
module scancode_decoder_key_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] popped_key,
    output logic       queue_nonempty,
    output logic       any_key_down,
    output logic       key_is_down
);
    import sckq_pkg::*;

    logic       s1_valid_reg;
    logic [1:0] op_reg;
    logic [7:0] byte_reg;
    logic       prefix_reg;
    logic       prefix_next;
    logic       out_valid_reg;
    logic [2:0] popped_reg;
    logic [2:0] popped_next;
    logic       nonempty_reg;
    logic       any_down_reg;
    logic       key_down_reg;
    logic       key_down_next;
    logic       out_hold;
    logic       fire;
    logic       scan_key;
    logic       poll_sel;
    logic [2:0] make_key;

    key_req_t  key_req;
    key_rsp_t  key_rsp;
    fifo_req_t fifo_req;
    fifo_rsp_t fifo_rsp;

    assign out_hold = out_valid_reg && out_stall;
    assign in_stall = s1_valid_reg && out_hold;
    assign fire     = s1_valid_reg && !out_hold;
    assign make_key = translate_make(byte_reg[6:0], prefix_reg);

    always_comb
    begin
        scan_key      = 1'b0;
        poll_sel      = 1'b0;
        prefix_next   = prefix_reg;
        popped_next   = KEY_NONE;
        key_down_next = 1'b0;
        unique case (op_reg)
            OP_SCAN:
            begin
                if (byte_reg == BYTE_PREFIX)
                begin
                    prefix_next = 1'b1;
                end
                else
                begin
                    prefix_next = 1'b0;
                    scan_key    = 1'b1;
                end
            end
            OP_POLL:
            begin
                poll_sel    = 1'b1;
                popped_next = fifo_rsp.nonempty ? fifo_rsp.head_key : KEY_NONE;
            end
            OP_QUERY:
            begin
                key_down_next = !byte_reg[7] && key_rsp.is_down;
            end
            default:
            begin
                prefix_next = prefix_reg;
            end
        endcase
    end

    assign key_req.wr_en     = fire && scan_key;
    assign key_req.set       = !byte_reg[7];
    assign key_req.index     = byte_reg[KEY_IW-1:0];
    assign fifo_req.push     = fire && scan_key && !byte_reg[7] && (make_key != KEY_NONE);
    assign fifo_req.pop      = fire && poll_sel;
    assign fifo_req.push_key = make_key;

    sckq_key_table u_key_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (key_req),
        .rsp   (key_rsp)
    );

    sckq_event_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_event_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fifo_req),
        .rsp   (fifo_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prefix_reg    <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (!out_hold)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (fire)
            begin
                prefix_reg <= prefix_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg   <= opcode;
            byte_reg <= data_byte;
        end
        if (fire)
        begin
            popped_reg   <= popped_next;
            nonempty_reg <= fifo_rsp.nonempty_next;
            any_down_reg <= key_rsp.any_down_next;
            key_down_reg <= key_down_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign popped_key     = popped_reg;
    assign queue_nonempty = nonempty_reg;
    assign any_key_down   = any_down_reg;
    assign key_is_down    = key_down_reg;

endmodule

[sv/sckq_checker.sv]
// ----------------------------------------------------------------------------
// Scancode decoder key queue - port checker
// Port-level properties of the top level, bound onto every instance.
// ----------------------------------------------------------------------------
`include "scancode_decoder_key_queue_defines.svh"

module sckq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] popped_key,
    input logic       queue_nonempty,
    input logic       any_key_down,
    input logic       key_is_down
);

    `SCKQ_ASSERT_IN_RESET(a_reset_idle, !out_valid && !in_stall, "outputs busy during reset")

    `SCKQ_ASSERT_ALWAYS(a_stall_cause, !in_stall || (out_valid && out_stall), "input stall without output back-pressure")

    `SCKQ_ASSERT_ALWAYS(a_pop_query_excl, !out_valid || !(key_is_down && (popped_key != 3'd0)), "result mixes a pop and a query")

    `SCKQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(popped_key) && $stable(queue_nonempty) && $stable(any_key_down) && $stable(key_is_down), "stalled result changed")

endmodule

bind scancode_decoder_key_queue sckq_checker u_sckq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .popped_key     (popped_key),
    .queue_nonempty (queue_nonempty),
    .any_key_down   (any_key_down),
    .key_is_down    (key_is_down)
);

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// Scancode decoder key queue - testbench
// The test starts with a short directed table: reset state, empty
// queue, prefixed and plain makes, breaks, out-of-range queries and the
// spare opcode. Random request streams follow, along with a burst that fills
// the event queue while the output is held off. An in-bench model of the
// key table and event ring predicts the results of untyped requests.
// Results are checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sckq_pkg::*;

    localparam int QDEPTH = 64;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int N_DIRECTED = 27;

    typedef struct packed {
        logic [2:0] key;
        logic       nonempty;
        logic       any_down;
        logic       is_down;
    } key_status_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  byte_val;
        logic        typed;
        key_status_t want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] opcode = OP_SCAN;
    logic [7:0] data_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] popped_key;
    logic       queue_nonempty;
    logic       any_key_down;
    logic       key_is_down;

    // in-bench copy of the block state
    logic [KEY_COUNT-1:0] key_table = '0;
    logic [2:0]           evt_ring [QDEPTH];
    logic [PTR_W-1:0]     wr_ptr = '0;
    logic [PTR_W-1:0]     rd_ptr = '0;
    logic                 prefix_armed = 1'b0;

    key_status_t pending_status [$];
    key_status_t oldest;
    stim_row_t   directed_rows [N_DIRECTED];
    int          errors = 0;
    int          accepted = 0;
    int          tx_idle_pct = 25;
    int          rx_idle_pct = 63;
    int          hold_left = 0;

    scancode_decoder_key_queue #(
        .QUEUE_DEPTH(QDEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .popped_key    (popped_key),
        .queue_nonempty(queue_nonempty),
        .any_key_down  (any_key_down),
        .key_is_down   (key_is_down)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rx_idle_pct);
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        if (errors <= 100)
            $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_status.size() == 0)
                report("result with no request pending, popped_key", int'(popped_key), 0);
            else
            begin
                oldest = pending_status.pop_front();
                if (popped_key !== oldest.key)
                    report("popped_key", int'(popped_key), int'(oldest.key));
                if (queue_nonempty !== oldest.nonempty)
                    report("queue_nonempty", int'(queue_nonempty), int'(oldest.nonempty));
                if (any_key_down !== oldest.any_down)
                    report("any_key_down", int'(any_key_down), int'(oldest.any_down));
                if (key_is_down !== oldest.is_down)
                    report("key_is_down", int'(key_is_down), int'(oldest.is_down));
            end
        end
    end

    function automatic key_status_t decode_request(input logic [1:0] op,
                                                   input logic [7:0] b);
        key_status_t      s;
        logic [2:0]       k;
        logic [PTR_W-1:0] nxt;
        s = '0;
        case (op)
            OP_SCAN:
            begin
                if (b == BYTE_PREFIX)
                    prefix_armed = 1'b1;
                else
                begin
                    k = KEY_NONE;
                    if (!b[7])
                    begin
                        case (b[6:0])
                            SCAN_ESC:    k = KEY_ESC;
                            SCAN_RETURN: k = KEY_ENTER;
                            SCAN_BLANK:  k = KEY_SPACE;
                            SCAN_UP:     k = prefix_armed ? KEY_UP : KEY_NONE;
                            SCAN_DOWN:   k = prefix_armed ? KEY_DOWN : KEY_NONE;
                            SCAN_LEFT:   k = prefix_armed ? KEY_LEFT : KEY_NONE;
                            SCAN_EAST:   k = prefix_armed ? KEY_RIGHT : KEY_NONE;
                            default:     k = KEY_NONE;
                        endcase
                    end
                    key_table[b[6:0]] = !b[7];
                    prefix_armed = 1'b0;
                    nxt = wr_ptr + 1'b1;
                    // one slot is kept free, so a full ring drops the push
                    if (k != KEY_NONE && nxt != rd_ptr)
                    begin
                        evt_ring[wr_ptr] = k;
                        wr_ptr = nxt;
                    end
                end
            end
            OP_POLL:
            begin
                if (wr_ptr != rd_ptr)
                begin
                    s.key = evt_ring[rd_ptr];
                    rd_ptr = rd_ptr + 1'b1;
                end
            end
            OP_QUERY:
            begin
                if (!b[7])
                    s.is_down = key_table[b[6:0]];
            end
            default: ;
        endcase
        s.nonempty = (wr_ptr != rd_ptr);
        s.any_down = |key_table;
        return s;
    endfunction

    task automatic offer(input logic [1:0] op, input logic [7:0] b,
                         input logic typed, input key_status_t want);
        key_status_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = decode_request(op, b);
        pending_status.push_back(typed ? want : predicted);
        accepted++;
    endtask

    task automatic park_until_drained();
        in_valid <= 1'b0;
        wait (pending_status.size() == 0);
        @(posedge clk);
    endtask

    function automatic logic [6:0] pick_key();
        case ($urandom_range(0, 6))
            0:       return SCAN_ESC;
            1:       return SCAN_RETURN;
            2:       return SCAN_BLANK;
            3:       return SCAN_UP;
            4:       return SCAN_DOWN;
            5:       return SCAN_LEFT;
            default: return SCAN_EAST;
        endcase
    endfunction

    function automatic stim_row_t row(input logic [1:0] op, input logic [7:0] b,
                                      input logic typed, input logic [2:0] key,
                                      input logic ne, input logic ad, input logic kd);
        stim_row_t r;
        r.op       = op;
        r.byte_val = b;
        r.typed    = typed;
        r.want     = {key, ne, ad, kd};
        return r;
    endfunction

    task automatic random_request();
        int         pick;
        logic [6:0] code;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            code = pick_key();
            if ($urandom_range(0, 3) != 0)
                offer(OP_SCAN, BYTE_PREFIX, 1'b0, '0);
            offer(OP_SCAN, {($urandom_range(0, 3) == 0), code}, 1'b0, '0);
        end
        else if (pick < 65)
            offer(OP_POLL, 8'($urandom_range(0, 255)), 1'b0, '0);
        else if (pick < 80)
        begin
            if ($urandom_range(0, 9) < 6)
                offer(OP_QUERY, {1'b0, pick_key()}, 1'b0, '0);
            else
                offer(OP_QUERY, 8'($urandom_range(0, 255)), 1'b0, '0);
        end
        else if (pick < 95)
            offer(OP_SCAN, 8'($urandom_range(0, 255)), 1'b0, '0);
        else
            offer(OP_SPARE, 8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    initial
    begin
        directed_rows = '{
            row(OP_QUERY, 8'h00, 1'b1, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_POLL,  8'h00, 1'b1, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SPARE, 8'hFF, 1'b1, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'h01, 1'b1, KEY_NONE, 1'b1, 1'b1, 1'b0),
            row(OP_QUERY, 8'h01, 1'b1, KEY_NONE, 1'b1, 1'b1, 1'b1),
            row(OP_QUERY, 8'hFF, 1'b1, KEY_NONE, 1'b1, 1'b1, 1'b0),
            row(OP_SCAN,  8'h81, 1'b1, KEY_NONE, 1'b1, 1'b0, 1'b0),
            row(OP_POLL,  8'h00, 1'b1, KEY_ESC,  1'b0, 1'b0, 1'b0),
            row(OP_POLL,  8'hFF, 1'b1, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'hE0, 1'b1, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'h48, 1'b0, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'hE0, 1'b0, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'h50, 1'b0, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'hE0, 1'b0, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'h4B, 1'b0, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'hE0, 1'b0, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'h4D, 1'b0, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'hE0, 1'b0, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'h1C, 1'b0, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'h1C, 1'b0, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'h39, 1'b0, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'h48, 1'b0, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'hE0, 1'b0, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'hC8, 1'b0, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'h50, 1'b0, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'h00, 1'b0, KEY_NONE, 1'b0, 1'b0, 1'b0),
            row(OP_SCAN,  8'hFF, 1'b0, KEY_NONE, 1'b0, 1'b0, 1'b0)
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer(directed_rows[i].op, directed_rows[i].byte_val,
                  directed_rows[i].typed, directed_rows[i].want);

        // fill the event ring past full while the output is held off
        hold_left <= 300;
        repeat (80)
        begin
            offer(OP_SCAN, BYTE_PREFIX, 1'b0, '0);
            offer(OP_SCAN, {1'b0, pick_key()}, 1'b0, '0);
        end
        park_until_drained();
        repeat (70)
            offer(OP_POLL, 8'($urandom_range(0, 255)), 1'b0, '0);

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 63 : 0;
            rx_idle_pct <= (phase == 0) ? 63 : (phase == 1) ? 25 : 0;
            if (phase == 1)
                park_until_drained();
            while (accepted < 300 + 290 * (phase + 1))
                random_request();
        end

        in_valid <= 1'b0;
        wait (pending_status.size() == 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/sckq_pkg.sv
sv/sckq_key_table.sv
sv/sckq_event_fifo.sv
sv/scancode_decoder_key_queue.sv
sv/sckq_checker.sv
sim/tb_top.sv
